@@ sv/swept_box_collision_macros.svh @@
// Assertion macros for the swept box collision block.
// Used by swept_box_collision.sv; needs no other file.
`ifndef SWEPT_BOX_COLLISION_MACROS_SVH
`define SWEPT_BOX_COLLISION_MACROS_SVH

// Implication checked on the next edge, off during reset
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked on the same edge, off during reset
`define SBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/swb_pkg.sv @@
// Shared constants for the swept box collision block.
// No dependencies.
package swb_pkg;

    localparam int COORD_WIDTH_DEF    = 24;
    localparam int TIME_FRAC_BITS_DEF = 16;
    localparam int TIME_WIDTH         = 32;
    // wide time with room for the open-slab limits
    localparam int TIME_EXT_WIDTH     = 42;
    localparam int OPEN_SHIFT         = 40;

    // axis normal codes
    localparam logic signed [1:0] NRM_ZERO = 2'sb00;
    localparam logic signed [1:0] NRM_POS  = 2'sb01;
    localparam logic signed [1:0] NRM_NEG  = 2'sb11;

endpackage

@@ sv/swept_box_collision.sv @@
// Swept box collision: pipelined ray/slab test of a moving box against a fixed box.
// Depends on swb_pkg and swept_box_collision_macros.svh.
//
// Usage:
//   Slave channel s_axis_* carries one box pair per transaction: mover corners,
//   velocity and target corners. Master channel m_axis_* returns one result per
//   transaction: hit flag, entry time, contact point and axis normal.
//   Throughput: one transaction per cycle unless the receiver stalls. The input
//   register is loaded at the accepting edge, then the restoring divider takes
//   COORD_WIDTH + TIME_FRAC_BITS + 1 stages, one quotient bit per stage for four
//   slab times in parallel, followed by a compare stage, a multiply stage and a
//   round/saturate stage.
//   Reset (synchronous, active low) clears all valid bits; payload is kept.
//   When the receiver stalls, the whole pipeline holds in place and
//   s_axis_tready drops; nothing is dropped or repeated.
//   The divider lanes compute (numerator << TIME_FRAC_BITS) / velocity as an
//   unsigned magnitude, the sign is applied and saturated to 32 bits after.
`include "swept_box_collision_macros.svh"

module swept_box_collision
    import swb_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // from bit 0: mover_min_x, mover_min_y, mover_max_x, mover_max_y,
    // velocity_x, velocity_y, target_min_x, target_min_y, target_max_x, target_max_y
    input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // from bit 0: hit, hit_time, contact_x, contact_y, normal_x, normal_y
    output logic [((37+2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = TIME_FRAC_BITS;
    localparam int NW    = CW + 1;          // numerator magnitude bits
    localparam int QW    = NW + FB;         // quotient bits = divider stages
    localparam int RW    = CW + 1;          // partial remainder bits
    localparam int QX    = (QW > TIME_WIDTH) ? QW : TIME_WIDTH + 1;
    localparam int TX    = TIME_EXT_WIDTH;
    localparam int PW    = TIME_WIDTH + CW;
    localparam int AW    = TIME_WIDTH + CW + 2;
    localparam int OUT_W = 1 + TIME_WIDTH + 2 * CW + 4;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    localparam logic [QX-1:0] Q_TMAX = QX'((64'd1 << (TIME_WIDTH - 1)) - 64'd1);
    localparam logic [QX-1:0] Q_TMIN = QX'(64'd1 << (TIME_WIDTH - 1));
    localparam logic signed [TX-1:0] T_OPEN = TX'(64'sd1 <<< OPEN_SHIFT);
    localparam logic signed [TX-1:0] T_ONE  = TX'(64'sd1 <<< FB);
    localparam logic signed [AW-1:0] C_HI   = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] C_LO   = -C_HI - AW'(1);
    localparam logic signed [AW-1:0] C_HALF = AW'(64'sd1 <<< (FB - 1));

    // lane order: near x, far x, near y, far y
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QW-1:0] dq;
    } t_lane;

    typedef struct packed {
        logic signed [CW:0]   sum_x;
        logic signed [CW:0]   sum_y;
        logic signed [CW-1:0] vx;
        logic signed [CW-1:0] vy;
        logic [CW-1:0]        dmag_x;
        logic [CW-1:0]        dmag_y;
        logic                 zero_x;
        logic                 zero_y;
        logic                 open_x;
        logic                 open_y;
        logic [3:0]           neg;
    } t_side;

    // one restoring division step
    function automatic t_lane div_step(input t_lane x, input logic [CW-1:0] d);
        logic [RW-1:0] trial;
        logic          take;
        t_lane         y;
        trial = {x.rem[RW-2:0], x.dq[QW-1]};
        take  = (trial >= {1'b0, d});
        y.rem = take ? (trial - {1'b0, d}) : trial;
        y.dq  = {x.dq[QW-2:0], take};
        return y;
    endfunction

    // sign and saturate a quotient magnitude to 32 bits
    function automatic logic signed [TIME_WIDTH-1:0] sat_q(input logic [QW-1:0] q,
                                                            input logic neg);
        logic [QX-1:0] qx;
        logic signed [TIME_WIDTH-1:0] r;
        qx = QX'(q);
        if (!neg) begin
            r = (qx > Q_TMAX) ? TIME_WIDTH'(Q_TMAX) : qx[TIME_WIDTH-1:0];
        end else begin
            r = (qx > Q_TMIN) ? TIME_WIDTH'(Q_TMIN) : -qx[TIME_WIDTH-1:0];
        end
        return r;
    endfunction

    logic en;

    // ---------------- input register ----------------
    logic signed [CW-1:0] in_f [0:9];
    logic signed [CW:0]   n_num [0:3];
    logic [NW-1:0]        n_mag [0:3];
    t_side                n_side;

    t_lane r_lane [0:QW][0:3];
    t_side r_side [0:QW];
    logic  r_v    [0:QW];

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            in_f[i] = s_axis_tdata[i*CW +: CW];
        end
        n_num[0] = {in_f[6][CW-1], in_f[6]} - {in_f[2][CW-1], in_f[2]};
        n_num[1] = {in_f[8][CW-1], in_f[8]} - {in_f[0][CW-1], in_f[0]};
        n_num[2] = {in_f[7][CW-1], in_f[7]} - {in_f[3][CW-1], in_f[3]};
        n_num[3] = {in_f[9][CW-1], in_f[9]} - {in_f[1][CW-1], in_f[1]};
        for (int i = 0; i < 4; i++) begin
            n_mag[i] = n_num[i][CW] ? NW'(-n_num[i]) : NW'(n_num[i]);
        end
        n_side.sum_x  = {in_f[0][CW-1], in_f[0]} + {in_f[2][CW-1], in_f[2]};
        n_side.sum_y  = {in_f[1][CW-1], in_f[1]} + {in_f[3][CW-1], in_f[3]};
        n_side.vx     = in_f[4];
        n_side.vy     = in_f[5];
        n_side.dmag_x = in_f[4][CW-1] ? CW'(-in_f[4]) : CW'(in_f[4]);
        n_side.dmag_y = in_f[5][CW-1] ? CW'(-in_f[5]) : CW'(in_f[5]);
        n_side.zero_x = (in_f[4] == '0);
        n_side.zero_y = (in_f[5] == '0);
        n_side.open_x = (n_num[0] <= 0) && (n_num[1] >= 0);
        n_side.open_y = (n_num[2] <= 0) && (n_num[3] >= 0);
        n_side.neg[0] = n_num[0][CW] ^ in_f[4][CW-1];
        n_side.neg[1] = n_num[1][CW] ^ in_f[4][CW-1];
        n_side.neg[2] = n_num[2][CW] ^ in_f[5][CW-1];
        n_side.neg[3] = n_num[3][CW] ^ in_f[5][CW-1];
    end

    // ---------------- input register and divider stages, one quotient bit each --------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= s_axis_tvalid;
            for (int k = 1; k <= QW; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
        if (en) begin
            r_side[0] <= n_side;
            for (int i = 0; i < 4; i++) begin
                r_lane[0][i].rem <= '0;
                r_lane[0][i].dq  <= {n_mag[i], {FB{1'b0}}};
            end
            for (int k = 1; k <= QW; k++) begin
                r_side[k]    <= r_side[k-1];
                r_lane[k][0] <= div_step(r_lane[k-1][0], r_side[k-1].dmag_x);
                r_lane[k][1] <= div_step(r_lane[k-1][1], r_side[k-1].dmag_x);
                r_lane[k][2] <= div_step(r_lane[k-1][2], r_side[k-1].dmag_y);
                r_lane[k][3] <= div_step(r_lane[k-1][3], r_side[k-1].dmag_y);
            end
        end
    end

    // ---------------- slab compare stage ----------------
    logic signed [TIME_WIDTH-1:0] q_t [0:3];
    logic signed [TX-1:0] a_x, b_x, a_y, b_y, tn_x, tf_x, tn_y, tf_y, t_near, t_far;
    logic                 n_miss, n_hit;
    logic signed [1:0]    n_nx, n_ny;
    t_side                s_fin;

    always_comb begin
        s_fin = r_side[QW];
        for (int i = 0; i < 4; i++) begin
            q_t[i] = sat_q(r_lane[QW][i].dq, s_fin.neg[i]);
        end
        a_x = TX'(q_t[0]);
        b_x = TX'(q_t[1]);
        a_y = TX'(q_t[2]);
        b_y = TX'(q_t[3]);
        if (s_fin.zero_x) begin
            tn_x = -T_OPEN;
            tf_x = T_OPEN;
        end else begin
            tn_x = (a_x > b_x) ? b_x : a_x;
            tf_x = (a_x > b_x) ? a_x : b_x;
        end
        if (s_fin.zero_y) begin
            tn_y = -T_OPEN;
            tf_y = T_OPEN;
        end else begin
            tn_y = (a_y > b_y) ? b_y : a_y;
            tf_y = (a_y > b_y) ? a_y : b_y;
        end
        t_near = (tn_x > tn_y) ? tn_x : tn_y;
        t_far  = (tf_x < tf_y) ? tf_x : tf_y;
        n_miss = (s_fin.zero_x && s_fin.zero_y)
              || (s_fin.zero_x && !s_fin.open_x)
              || (s_fin.zero_y && !s_fin.open_y)
              || (tn_x > tf_y) || (tn_y > tf_x)
              || (t_far < 0);
        n_hit  = (t_near <= T_ONE);
        n_nx   = NRM_ZERO;
        n_ny   = NRM_ZERO;
        if (tn_x > tn_y) begin
            n_nx = s_fin.vx[CW-1] ? NRM_POS : NRM_NEG;
        end else if (tn_x < tn_y) begin
            n_ny = s_fin.vy[CW-1] ? NRM_POS : NRM_NEG;
        end
    end

    logic                         r_p_v, r_p_miss, r_p_hit;
    logic signed [TIME_WIDTH-1:0] r_p_t;
    logic signed [1:0]            r_p_nx, r_p_ny;
    t_side                        r_p_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= r_v[QW];
        end
        if (en) begin
            r_p_miss <= n_miss;
            r_p_hit  <= n_hit;
            r_p_t    <= t_near[TIME_WIDTH-1:0];
            r_p_nx   <= n_nx;
            r_p_ny   <= n_ny;
            r_p_side <= s_fin;
        end
    end

    // ---------------- displacement multiply stage ----------------
    logic                         r_m_v, r_m_miss, r_m_hit;
    logic signed [TIME_WIDTH-1:0] r_m_t;
    logic signed [1:0]            r_m_nx, r_m_ny;
    logic signed [CW:0]           r_m_sx, r_m_sy;
    logic signed [PW-1:0]         r_m_px, r_m_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_p_v;
        end
        if (en) begin
            r_m_miss <= r_p_miss;
            r_m_hit  <= r_p_hit;
            r_m_t    <= r_p_t;
            r_m_nx   <= r_p_nx;
            r_m_ny   <= r_p_ny;
            r_m_sx   <= r_p_side.sum_x;
            r_m_sy   <= r_p_side.sum_y;
            r_m_px   <= r_p_t * r_p_side.vx;
            r_m_py   <= r_p_t * r_p_side.vy;
        end
    end

    // ---------------- round, saturate and output register ----------------
    logic signed [AW-1:0] acc_x, acc_y, rnd_x, rnd_y;
    logic signed [CW-1:0] n_cx, n_cy;

    always_comb begin
        acc_x = (AW'(r_m_sx) <<< (FB - 1)) + AW'(r_m_px) + C_HALF;
        acc_y = (AW'(r_m_sy) <<< (FB - 1)) + AW'(r_m_py) + C_HALF;
        rnd_x = acc_x >>> FB;
        rnd_y = acc_y >>> FB;
        n_cx  = (rnd_x > C_HI) ? CW'(C_HI) : ((rnd_x < C_LO) ? CW'(C_LO) : rnd_x[CW-1:0]);
        n_cy  = (rnd_y > C_HI) ? CW'(C_HI) : ((rnd_y < C_LO) ? CW'(C_LO) : rnd_y[CW-1:0]);
    end

    logic                         r_o_v, r_o_hit;
    logic signed [TIME_WIDTH-1:0] r_o_t;
    logic signed [CW-1:0]         r_o_cx, r_o_cy;
    logic signed [1:0]            r_o_nx, r_o_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_m_v;
        end
        if (en) begin
            r_o_hit <= !r_m_miss && r_m_hit;
            r_o_t   <= r_m_miss ? '0 : r_m_t;
            r_o_cx  <= r_m_miss ? '0 : n_cx;
            r_o_cy  <= r_m_miss ? '0 : n_cy;
            r_o_nx  <= r_m_miss ? NRM_ZERO : r_m_nx;
            r_o_ny  <= r_m_miss ? NRM_ZERO : r_m_ny;
        end
    end

    // whole pipeline advances unless a finished result is held
    assign en            = m_axis_tready || !r_o_v;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_o_v;
    assign m_axis_tdata  = OUT_TW'({r_o_ny, r_o_nx, r_o_cy, r_o_cx, r_o_t, r_o_hit});

    // ---------------- assertions ----------------
    `SBC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_v[0], "accepted transaction not captured")
    `SBC_ASSERT_SAME(a_stall_blocks, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during output stall")
    `SBC_ASSERT_SAME(a_hit_in_step, i_clk, i_rst_n,
        m_axis_tvalid && r_o_hit, r_o_t <= TIME_WIDTH'(T_ONE), "hit with entry time past step")
    `SBC_ASSERT_SAME(a_single_normal, i_clk, i_rst_n,
        m_axis_tvalid && (r_o_nx != NRM_ZERO), r_o_ny == NRM_ZERO, "two normal axes set")

endmodule
